### src/atl_pkg.sv
// types, constants and character-class helpers for the assembly token lexer
// no dependencies; used by every module of the block by scoped names
package atl_pkg;

  localparam int unsigned LINE_W    = 20;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = 2;
  localparam int unsigned OUTQ_CNT_W = 3;

  localparam logic [LINE_W-1:0] FIRST_LINE_RST = 20'd1;
  localparam logic [LINE_W-1:0] LINE_MAX       = 20'hFFFFF;

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_AT      = 8'h40;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

  typedef enum logic [3:0] {
    KIND_DIRECTIVE = 4'd0,
    KIND_IDENT     = 4'd1,
    KIND_REGISTER  = 4'd2,
    KIND_NUMBER    = 4'd3,
    KIND_COMMA     = 4'd4,
    KIND_SEMI      = 4'd5,
    KIND_COLON     = 4'd6,
    KIND_LPAREN    = 4'd7,
    KIND_RPAREN    = 4'd8,
    KIND_AT        = 4'd9,
    KIND_END       = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_REG  = 2'd2,
    MODE_NUM  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              end_of_source;
  } in_word_t;

  typedef struct packed {
    logic [3:0]        token_kind;
    logic [CHAR_W-1:0] token_byte;
    logic              byte_valid;
    logic              token_done;
    logic [LINE_W-1:0] line_number;
    logic              last_of_run;
  } out_word_t;

  typedef struct packed {
    mode_e             mode;
    kind_e             kind;
    logic              slash;
    logic              comment;
    logic [LINE_W-1:0] line;
  } scan_state_t;

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

### src/atl_step.sv
// lexer step: next scan state and up to two result words for one byte
// depends on atl_pkg
module atl_step (
  input  atl_pkg::scan_state_t            state_i,
  input  atl_pkg::in_word_t               in_word_i,
  input  logic [atl_pkg::LINE_W-1:0]      first_line_i,
  output atl_pkg::scan_state_t            state_o,
  output atl_pkg::out_word_t              res0_o,
  output atl_pkg::out_word_t              res1_o,
  output logic [1:0]                      res_cnt_o
);

  logic [atl_pkg::CHAR_W-1:0] c;
  logic                       eos;
  logic                       cont;
  logic                       close_en;
  logic                       new_en;
  atl_pkg::out_word_t         close_res;
  atl_pkg::out_word_t         new_res;
  logic [atl_pkg::LINE_W-1:0] line_bump;

  assign c   = in_word_i.text_char;
  assign eos = in_word_i.end_of_source || (c == atl_pkg::CH_NUL);

  assign line_bump = (state_i.line == atl_pkg::LINE_MAX) ? state_i.line
                                                         : state_i.line + 1'b1;

  always_comb begin
    case (state_i.mode)
      atl_pkg::MODE_WORD: cont = atl_pkg::is_alpha(c) || atl_pkg::is_digit(c) ||
                                 c == atl_pkg::CH_DOT || c == atl_pkg::CH_UNDER;
      atl_pkg::MODE_REG:  cont = atl_pkg::is_alpha(c) || atl_pkg::is_digit(c) ||
                                 c == atl_pkg::CH_UNDER;
      atl_pkg::MODE_NUM:  cont = atl_pkg::is_digit(c) || c == atl_pkg::CH_DOT;
      default:            cont = 1'b0;
    endcase
  end

  always_comb begin
    state_o   = state_i;
    close_en  = 1'b0;
    new_en    = 1'b0;
    close_res = '0;
    new_res   = '0;
    close_res.token_kind  = state_i.kind;
    close_res.token_done  = 1'b1;
    close_res.line_number = state_i.line;
    new_res.line_number   = state_i.line;

    if (eos) begin
      close_en = (state_i.mode != atl_pkg::MODE_IDLE);
      new_en   = 1'b1;
      new_res.token_kind = atl_pkg::KIND_END;
      new_res.token_done = 1'b1;
      state_o.mode    = atl_pkg::MODE_IDLE;
      state_o.kind    = atl_pkg::KIND_DIRECTIVE;
      state_o.slash   = 1'b0;
      state_o.comment = 1'b0;
      state_o.line    = first_line_i;
    end else if (state_i.comment) begin
      if (c == atl_pkg::CH_NL) begin
        state_o.comment = 1'b0;
        state_o.line    = line_bump;
      end
    end else if (state_i.slash && c == atl_pkg::CH_SLASH) begin
      state_o.slash   = 1'b0;
      state_o.comment = 1'b1;
    end else if (state_i.mode != atl_pkg::MODE_IDLE && cont) begin
      // byte extends the open token
      state_o.slash      = 1'b0;
      new_en             = 1'b1;
      new_res.token_kind = state_i.kind;
      new_res.token_byte = c;
      new_res.byte_valid = 1'b1;
    end else begin
      state_o.slash = 1'b0;
      if (state_i.mode != atl_pkg::MODE_IDLE) begin
        close_en     = 1'b1;
        state_o.mode = atl_pkg::MODE_IDLE;
        state_o.kind = atl_pkg::KIND_DIRECTIVE;
      end
      new_res.token_byte = c;
      new_res.byte_valid = 1'b1;
      if (c == atl_pkg::CH_NL) begin
        state_o.line = line_bump;
      end else if (atl_pkg::is_space(c)) begin
        // dropped
      end else if (c == atl_pkg::CH_SLASH) begin
        state_o.slash = 1'b1;
      end else if (atl_pkg::is_alpha(c) || c == atl_pkg::CH_DOT ||
                   c == atl_pkg::CH_UNDER) begin
        new_en       = 1'b1;
        state_o.mode = atl_pkg::MODE_WORD;
        state_o.kind = (c == atl_pkg::CH_DOT) ? atl_pkg::KIND_DIRECTIVE
                                              : atl_pkg::KIND_IDENT;
        new_res.token_kind = state_o.kind;
      end else if (c == atl_pkg::CH_PERCENT) begin
        new_en             = 1'b1;
        state_o.mode       = atl_pkg::MODE_REG;
        state_o.kind       = atl_pkg::KIND_REGISTER;
        new_res.token_kind = atl_pkg::KIND_REGISTER;
      end else if (atl_pkg::is_digit(c) || c == atl_pkg::CH_MINUS) begin
        new_en             = 1'b1;
        state_o.mode       = atl_pkg::MODE_NUM;
        state_o.kind       = atl_pkg::KIND_NUMBER;
        new_res.token_kind = atl_pkg::KIND_NUMBER;
      end else begin
        // punctuation is a lone done word
        new_res.token_byte = '0;
        new_res.byte_valid = 1'b0;
        new_res.token_done = 1'b1;
        new_en             = 1'b1;
        case (c)
          atl_pkg::CH_COMMA:  new_res.token_kind = atl_pkg::KIND_COMMA;
          atl_pkg::CH_SEMI:   new_res.token_kind = atl_pkg::KIND_SEMI;
          atl_pkg::CH_COLON:  new_res.token_kind = atl_pkg::KIND_COLON;
          atl_pkg::CH_LPAREN: new_res.token_kind = atl_pkg::KIND_LPAREN;
          atl_pkg::CH_RPAREN: new_res.token_kind = atl_pkg::KIND_RPAREN;
          atl_pkg::CH_AT:     new_res.token_kind = atl_pkg::KIND_AT;
          default:            new_en = 1'b0;
        endcase
      end
    end
  end

  // close word goes first, the new token's word after it
  always_comb begin
    res_cnt_o = {1'b0, close_en} + {1'b0, new_en};
    res0_o    = close_en ? close_res : new_res;
    res1_o    = new_res;
    res0_o.last_of_run = (res_cnt_o == 2'd1);
    res1_o.last_of_run = 1'b1;
  end

endmodule

### src/atl_outq.sv
// result queue: takes up to two words per cycle, hands out one per cycle while out_stall_i is low
// depends on atl_pkg
module atl_outq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [1:0]                       wr_cnt_i,
  input  atl_pkg::out_word_t               wr0_i,
  input  atl_pkg::out_word_t               wr1_i,
  output logic                             room_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output atl_pkg::out_word_t               out_word_o
);

  atl_pkg::out_word_t                  mem_q [atl_pkg::OUTQ_DEPTH];
  logic [atl_pkg::OUTQ_PTR_W-1:0]      rptr_q, rptr_d;
  logic [atl_pkg::OUTQ_PTR_W-1:0]      wptr_q, wptr_d;
  logic [atl_pkg::OUTQ_CNT_W-1:0]      cnt_q, cnt_d;
  logic [atl_pkg::OUTQ_PTR_W-1:0]      wptr_p1;
  logic                                pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = mem_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= atl_pkg::OUTQ_CNT_W'(atl_pkg::OUTQ_DEPTH - 2));
  assign wptr_p1     = wptr_q + 1'b1;

  always_comb begin
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    wptr_d = wptr_q + atl_pkg::OUTQ_PTR_W'(wr_cnt_i);
    cnt_d  = cnt_q + atl_pkg::OUTQ_CNT_W'(wr_cnt_i) - atl_pkg::OUTQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0;
      wptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= wr0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wptr_p1] <= wr1_i;
    end
  end

endmodule

### src/assembly_token_lexer_unit.sv
// top level of the assembly token lexer: input register, scan state, result queue
// depends on atl_pkg, atl_step and atl_outq
//
// Source bytes enter one word per cycle through an input register while
// in_stall_o is low; the scan state (open token kind, pending slash, comment
// flag, line count) updates in the same cycle a byte is processed, and the
// result words it causes (none, one or two) go into a four-entry result queue.
// A byte is taken every cycle while the queue has room for two words; the
// output port drains one word per cycle while out_stall_i is low.
// Writing first_line also reloads the line count; end of source (or byte 0)
// closes any open token, emits an End token and restores idle, line = first_line.
module assembly_token_lexer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  atl_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output atl_pkg::out_word_t          out_word_o,
  input  logic                        cfg_we_i,
  input  logic [atl_pkg::LINE_W-1:0]  cfg_wdata_i
);

  logic                       in_vld_q;
  atl_pkg::in_word_t          in_q;
  logic [atl_pkg::LINE_W-1:0] first_line_q;
  atl_pkg::scan_state_t       state_q, state_d;
  atl_pkg::scan_state_t       step_state;
  atl_pkg::out_word_t         res0, res1;
  logic [1:0]                 res_cnt;
  logic [1:0]                 wr_cnt;
  logic                       room;
  logic                       go;

  assign go         = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign wr_cnt     = go ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  atl_step u_step (
    .state_i      (state_q),
    .in_word_i    (in_q),
    .first_line_i (first_line_q),
    .state_o      (step_state),
    .res0_o       (res0),
    .res1_o       (res1),
    .res_cnt_o    (res_cnt)
  );

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d.line = cfg_wdata_i;
    end else if (go) begin
      state_d = step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q  <= atl_pkg::FIRST_LINE_RST;
      state_q.mode    <= atl_pkg::MODE_IDLE;
      state_q.kind    <= atl_pkg::KIND_DIRECTIVE;
      state_q.slash   <= 1'b0;
      state_q.comment <= 1'b0;
      state_q.line    <= atl_pkg::FIRST_LINE_RST;
    end else begin
      if (cfg_we_i) begin
        first_line_q <= cfg_wdata_i;
      end
      state_q <= state_d;
    end
  end

  atl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_cnt_i    (wr_cnt),
    .wr0_i       (res0),
    .wr1_i       (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

### test/testbench.sv
// self-checking testbench for assembly_token_lexer_unit
// random source text in, token words checked against its own lexer state
// depends on atl_pkg and the block's RTL
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned ERR_PRINT    = 40;

  typedef enum int {STALL_NONE, STALL_SOME, STALL_MOST} stall_mode_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  atl_pkg::in_word_t          in_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  atl_pkg::out_word_t         out_word;
  logic                       cfg_we = 1'b0;
  logic [atl_pkg::LINE_W-1:0] cfg_wdata = '0;

  assembly_token_lexer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // source words waiting to be sent and token words waiting to be seen
  atl_pkg::in_word_t  text_fifo[$];
  atl_pkg::out_word_t token_fifo[$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // predicted lexer state
  atl_pkg::mode_e             scan_mode = atl_pkg::MODE_IDLE;
  atl_pkg::kind_e             open_kind = atl_pkg::KIND_DIRECTIVE;
  bit                         slash_seen = 1'b0;
  bit                         in_comment = 1'b0;
  logic [atl_pkg::LINE_W-1:0] line_cnt = atl_pkg::FIRST_LINE_RST;
  logic [atl_pkg::LINE_W-1:0] first_line = atl_pkg::FIRST_LINE_RST;

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit joins_token(logic [7:0] c);
    case (scan_mode)
      atl_pkg::MODE_WORD: return letter(c) || numeral(c) || c == atl_pkg::CH_DOT ||
                                 c == atl_pkg::CH_UNDER;
      atl_pkg::MODE_REG:  return letter(c) || numeral(c) || c == atl_pkg::CH_UNDER;
      atl_pkg::MODE_NUM:  return numeral(c) || c == atl_pkg::CH_DOT;
      default:            return 1'b0;
    endcase
  endfunction

  function automatic atl_pkg::out_word_t make_tok(atl_pkg::kind_e k, logic [7:0] b,
                                                  logic v, logic d);
    atl_pkg::out_word_t t;
    t.token_kind  = k;
    t.token_byte  = b;
    t.byte_valid  = v;
    t.token_done  = d;
    t.line_number = line_cnt;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  function automatic void next_line();
    if (line_cnt != atl_pkg::LINE_MAX) line_cnt = line_cnt + 1'b1;
  endfunction

  // lex one accepted source word and queue the token words it gives
  function automatic void lex_word(atl_pkg::in_word_t w);
    atl_pkg::out_word_t res[2];
    int                 n;
    bit                 handled;
    atl_pkg::kind_e     punct;
    bit                 is_punct;
    logic [7:0]         c;
    n = 0;
    handled = 1'b0;
    c = w.text_char;
    if (w.end_of_source || c == atl_pkg::CH_NUL) begin
      if (scan_mode != atl_pkg::MODE_IDLE) begin
        res[n] = make_tok(open_kind, 8'h00, 1'b0, 1'b1);
        n++;
      end
      res[n] = make_tok(atl_pkg::KIND_END, 8'h00, 1'b0, 1'b1);
      n++;
      scan_mode  = atl_pkg::MODE_IDLE;
      open_kind  = atl_pkg::KIND_DIRECTIVE;
      slash_seen = 1'b0;
      in_comment = 1'b0;
      line_cnt   = first_line;
    end else if (in_comment) begin
      if (c == atl_pkg::CH_NL) begin
        in_comment = 1'b0;
        next_line();
      end
    end else begin
      if (slash_seen) begin
        slash_seen = 1'b0;
        if (c == atl_pkg::CH_SLASH) begin
          in_comment = 1'b1;
          handled = 1'b1;
        end
      end
      if (!handled && scan_mode != atl_pkg::MODE_IDLE) begin
        if (joins_token(c)) begin
          res[n] = make_tok(open_kind, c, 1'b1, 1'b0);
          n++;
          handled = 1'b1;
        end else begin
          res[n] = make_tok(open_kind, 8'h00, 1'b0, 1'b1);
          n++;
          scan_mode = atl_pkg::MODE_IDLE;
          open_kind = atl_pkg::KIND_DIRECTIVE;
        end
      end
      if (!handled) begin
        is_punct = 1'b1;
        punct = atl_pkg::KIND_END;
        case (c)
          atl_pkg::CH_COMMA:  punct = atl_pkg::KIND_COMMA;
          atl_pkg::CH_SEMI:   punct = atl_pkg::KIND_SEMI;
          atl_pkg::CH_COLON:  punct = atl_pkg::KIND_COLON;
          atl_pkg::CH_LPAREN: punct = atl_pkg::KIND_LPAREN;
          atl_pkg::CH_RPAREN: punct = atl_pkg::KIND_RPAREN;
          atl_pkg::CH_AT:     punct = atl_pkg::KIND_AT;
          default:            is_punct = 1'b0;
        endcase
        if (c == atl_pkg::CH_NL) begin
          next_line();
        end else if (c == atl_pkg::CH_SPACE ||
                     (c >= atl_pkg::CH_TAB && c <= atl_pkg::CH_CR)) begin
          // whitespace only closes
        end else if (c == atl_pkg::CH_SLASH) begin
          slash_seen = 1'b1;
        end else if (letter(c) || c == atl_pkg::CH_DOT || c == atl_pkg::CH_UNDER) begin
          scan_mode = atl_pkg::MODE_WORD;
          open_kind = (c == atl_pkg::CH_DOT) ? atl_pkg::KIND_DIRECTIVE
                                             : atl_pkg::KIND_IDENT;
          res[n] = make_tok(open_kind, c, 1'b1, 1'b0);
          n++;
        end else if (c == atl_pkg::CH_PERCENT) begin
          scan_mode = atl_pkg::MODE_REG;
          open_kind = atl_pkg::KIND_REGISTER;
          res[n] = make_tok(open_kind, c, 1'b1, 1'b0);
          n++;
        end else if (numeral(c) || c == atl_pkg::CH_MINUS) begin
          scan_mode = atl_pkg::MODE_NUM;
          open_kind = atl_pkg::KIND_NUMBER;
          res[n] = make_tok(open_kind, c, 1'b1, 1'b0);
          n++;
        end else if (is_punct) begin
          res[n] = make_tok(punct, 8'h00, 1'b0, 1'b1);
          n++;
        end
      end
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) token_fifo = {token_fifo, res[i]};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (err_cnt < ERR_PRINT)
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
      err_cnt++;
    end
  endfunction

  // driver: bursts of words with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (cfg_we) begin
      first_line = cfg_wdata;
      line_cnt   = cfg_wdata;
    end
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) lex_word(in_word);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_fifo.size() > 0) begin
          in_word  <= text_fifo.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks token words and stalls on a pattern of its own
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    atl_pkg::out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (token_fifo.size() == 0) begin
        if (err_cnt < ERR_PRINT)
          $display("%0t: unexpected word, expected none actual %h", $realtime, out_word);
        err_cnt++;
      end else begin
        want = token_fifo.pop_front();
        check_field("token_kind", 32'(want.token_kind), 32'(out_word.token_kind));
        check_field("token_byte", 32'(want.token_byte), 32'(out_word.token_byte));
        check_field("byte_valid", 32'(want.byte_valid), 32'(out_word.byte_valid));
        check_field("token_done", 32'(want.token_done), 32'(out_word.token_done));
        check_field("line_number", 32'(want.line_number), 32'(out_word.line_number));
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_word.last_of_run));
      end
    end
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(10, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_SOME: out_stall <= ($urandom_range(0, 2) == 0);
      default:    out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_byte(logic [7:0] c, logic eos);
    atl_pkg::in_word_t w;
    w.text_char = c;
    w.end_of_source = eos;
    text_fifo = {text_fifo, w};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // one random stretch of source: mostly well-formed tokens, some noise
  task automatic add_random_run();
    string alnum;
    int    sel;
    int    len;
    alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    sel = $urandom_range(0, 99);
    len = $urandom_range(0, 6);
    if (sel < 22) begin
      add_byte(pick({alnum.substr(0, 51), "_."}), 1'b0);
      for (int i = 0; i < len; i++) add_byte(pick({alnum, "_."}), 1'b0);
    end else if (sel < 34) begin
      add_byte(atl_pkg::CH_PERCENT, 1'b0);
      for (int i = 0; i < len; i++) add_byte(pick({alnum, "_"}), 1'b0);
    end else if (sel < 46) begin
      add_byte(pick("-0123456789"), 1'b0);
      for (int i = 0; i < len; i++) add_byte(pick("0123456789."), 1'b0);
    end else if (sel < 61) begin
      add_byte(pick(",;:()@"), 1'b0);
    end else if (sel < 76) begin
      case ($urandom_range(0, 2))
        0:       add_byte(atl_pkg::CH_SPACE, 1'b0);
        1:       add_byte(atl_pkg::CH_NL, 1'b0);
        default: add_byte(8'($urandom_range(9, 13)), 1'b0);
      endcase
    end else if (sel < 83) begin
      // comment, usually closed by a newline, sometimes by end of source
      add_text("//");
      for (int i = 0; i < len; i++) add_byte(8'($urandom_range(1, 255)), 1'b0);
      if ($urandom_range(0, 5) == 0) add_byte(8'($urandom_range(0, 255)), 1'b1);
      else add_byte(atl_pkg::CH_NL, 1'b0);
    end else if (sel < 89) begin
      add_byte(atl_pkg::CH_SLASH, 1'b0);
    end else if (sel < 97) begin
      add_byte(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0);
    end else begin
      add_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic wait_drained();
    while (text_fifo.size() > 0 || in_valid || token_fifo.size() > 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_first_line(logic [atl_pkg::LINE_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_random(int unsigned count);
    int unsigned base;
    base = text_fifo.size();
    while (text_fifo.size() - base < count) add_random_run();
  endtask

  initial begin
    logic [atl_pkg::LINE_W-1:0] line_set[5];
    line_set[0] = atl_pkg::LINE_MAX;
    line_set[1] = '0;
    line_set[2] = atl_pkg::LINE_W'($urandom_range(0, 20'hFFFFF));
    line_set[3] = atl_pkg::LINE_MAX - 1'b1;
    line_set[4] = atl_pkg::LINE_W'($urandom_range(2, 50));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every token kind, lone slash, comment, high byte, end of source
    // inside a comment and after a slash, and the nul byte
    add_text(".a9 %r,-9.;:()@/x//q\n");
    add_byte(8'hFF, 1'b0);
    add_text("//");
    add_byte(8'hA5, 1'b1);
    add_byte(atl_pkg::CH_SLASH, 1'b0);
    add_byte(8'h5A, 1'b1);
    add_byte("7", 1'b0);
    add_byte(atl_pkg::CH_NUL, 1'b0);
    add_random(250);
    wait_drained();

    foreach (line_set[i]) begin
      write_first_line(line_set[i]);
      add_random(260);
      wait_drained();
    end

    if (err_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
src/atl_pkg.sv
src/atl_step.sv
src/atl_outq.sv
src/assembly_token_lexer_unit.sv
test/testbench.sv
